// ===== rtl/subtractive_lagged_random_generator_defines.svh =====
// assertion macros for the generator's checker
`ifndef SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_DEFINES_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_DEFINES_SVH

// property checked on every clock edge outside reset
`define SLRG_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("slrg assertion failed");

// property checked on every clock edge, reset included
`define SLRG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("slrg assertion failed");

`endif

// ===== rtl/slrg_pkg.sv =====
`timescale 1ns / 1ps
package slrg_pkg;

  localparam int WORD_W = 30;
  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MODULUS = 30'd1000000000;
  localparam logic [31:0] SEED_CONST = 32'd161803398;

  localparam int TABLE_LEN   = 55;
  localparam int PERM_STEP   = 21;
  localparam int LAG_START   = 31;
  localparam int WARM_PASSES = 4;
  // fill words enter here so that a ring turning by the fill stride lands
  // each word at its permuted slot after the last fill step
  localparam int FILL_CELL   = 33;

  localparam int CNT_W = 8;
  typedef logic [CNT_W-1:0] count_t;
  localparam count_t FILL_LAST = count_t'(TABLE_LEN - 1);
  localparam count_t WARM_LAST = count_t'(WARM_PASSES * TABLE_LEN - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_INIT,
    ST_FILL,
    ST_WARM,
    ST_DRAW
  } state_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_STEP,
    RING_FILL
  } ring_op_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic init;
    logic step;
  } fill_ctl_t;

  function automatic word_t sub_mod(word_t a, word_t b);
    logic [WORD_W:0] wrap;
    wrap = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
    return (a >= b) ? word_t'(a - b) : wrap[WORD_W-1:0];
  endfunction

endpackage

// ===== rtl/slrg_cell.sv =====
`timescale 1ns / 1ps
module slrg_cell (
  input  logic                clk,
  input  slrg_pkg::ring_op_t  op,
  input  slrg_pkg::word_t     near,
  input  slrg_pkg::word_t     far,
  output slrg_pkg::word_t     word
);

  always_ff @(posedge clk) begin
    case (op)
      slrg_pkg::RING_STEP: word <= near;
      slrg_pkg::RING_FILL: word <= far;
      default:             word <= word;
    endcase
  end

endmodule

// ===== rtl/slrg_fill.sv =====
`timescale 1ns / 1ps
module slrg_fill (
  input  logic                clk,
  input  logic                rst,
  input  slrg_pkg::fill_ctl_t ctl,
  input  logic signed [31:0]  seed,
  output slrg_pkg::word_t     fill_word
);

  logic [31:0]            seed_bits;
  logic [31:0]            mag;
  logic [30:0]            diff;
  logic [30:0]            modulus_ext;
  slrg_pkg::word_t        first_word;
  slrg_pkg::word_t        prev;
  logic                   first;

  assign seed_bits   = seed;
  assign modulus_ext = {1'b0, slrg_pkg::MODULUS};
  assign first_word  = (diff >= modulus_ext) ? slrg_pkg::word_t'(diff - modulus_ext)
                                             : diff[slrg_pkg::WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag <= seed_bits[31] ? (~seed_bits + 32'd1) : seed_bits;
    end
    if (ctl.diff) begin
      diff <= (mag >= slrg_pkg::SEED_CONST) ? 31'(mag - slrg_pkg::SEED_CONST)
                                            : 31'(slrg_pkg::SEED_CONST - mag);
    end
    if (ctl.init) begin
      fill_word <= first_word;
    end else if (ctl.step) begin
      // words follow w[n+1] = w[n-1] - w[n], with w[1] = 1
      prev      <= fill_word;
      fill_word <= first ? slrg_pkg::word_t'(1) : slrg_pkg::sub_mod(prev, fill_word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
    end else if (ctl.init) begin
      first <= 1'b1;
    end else if (ctl.step) begin
      first <= 1'b0;
    end
  end

endmodule

// ===== rtl/slrg_ring.sv =====
`timescale 1ns / 1ps
module slrg_ring (
  input  logic               clk,
  input  slrg_pkg::ring_op_t op,
  input  slrg_pkg::word_t    fill_word,
  output slrg_pkg::word_t    draw_word
);

  localparam int LAST = slrg_pkg::TABLE_LEN - 1;

  // cell k holds the table word k places ahead of the lead word
  slrg_pkg::word_t words [slrg_pkg::TABLE_LEN];

  for (genvar k = 0; k < slrg_pkg::TABLE_LEN; k++) begin : g_cell
    slrg_pkg::word_t near;
    slrg_pkg::word_t far;

    if (k == LAST) begin : g_tail
      assign near = draw_word;
    end else begin : g_body
      assign near = words[k+1];
    end

    if (k == slrg_pkg::FILL_CELL) begin : g_inject
      assign far = fill_word;
    end else begin : g_stride
      assign far = words[(k + slrg_pkg::PERM_STEP) % slrg_pkg::TABLE_LEN];
    end

    slrg_cell u_cell (
      .clk  (clk),
      .op   (op),
      .near (near),
      .far  (far),
      .word (words[k])
    );
  end

  assign draw_word = slrg_pkg::sub_mod(words[0], words[slrg_pkg::LAG_START]);

endmodule

// ===== rtl/subtractive_lagged_random_generator.sv =====
`timescale 1ns / 1ps
// Subtractive lagged random generator: each accepted seed is one request and
// returns one deviate in 0..999999999 (fraction = deviate * 1e-9). The 55-word
// lag table lives in a ring of cells that turns by one place per draw, so an
// ordinary request is answered in the cycle after its transfer and requests can
// be taken every cycle while results are taken. A negative seed, or the first
// request after reset, rebuilds the table first: the seed magnitude, its distance
// from the seed constant, the first word, the fill steps and four warm-up passes
// through the same ring, and no request is taken meanwhile.
module subtractive_lagged_random_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] seed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [29:0]        deviate
);

  slrg_pkg::state_t    state;
  slrg_pkg::state_t    state_next;
  slrg_pkg::count_t    count;
  slrg_pkg::count_t    count_next;
  slrg_pkg::ring_op_t  op;
  slrg_pkg::fill_ctl_t fctl;
  slrg_pkg::word_t     fill_word;
  slrg_pkg::word_t     draw_word;
  logic                seeded;
  logic                accept;
  logic                reseed;
  logic                draw;

  assign in_ready = (state == slrg_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign reseed   = seed[31] || !seeded;

  always_comb begin
    state_next = state;
    count_next = count;
    op         = slrg_pkg::RING_HOLD;
    fctl       = '0;
    draw       = 1'b0;
    unique case (state)
      slrg_pkg::ST_IDLE: begin
        if (accept) begin
          if (reseed) begin
            fctl.load  = 1'b1;
            state_next = slrg_pkg::ST_DIFF;
          end else begin
            op   = slrg_pkg::RING_STEP;
            draw = 1'b1;
          end
        end
      end
      slrg_pkg::ST_DIFF: begin
        fctl.diff  = 1'b1;
        state_next = slrg_pkg::ST_INIT;
      end
      slrg_pkg::ST_INIT: begin
        fctl.init  = 1'b1;
        count_next = '0;
        state_next = slrg_pkg::ST_FILL;
      end
      slrg_pkg::ST_FILL: begin
        op        = slrg_pkg::RING_FILL;
        fctl.step = 1'b1;
        if (count == slrg_pkg::FILL_LAST) begin
          count_next = '0;
          state_next = slrg_pkg::ST_WARM;
        end else begin
          count_next = count + 1'b1;
        end
      end
      slrg_pkg::ST_WARM: begin
        // warm-up passes are plain draws with the result dropped
        op = slrg_pkg::RING_STEP;
        if (count == slrg_pkg::WARM_LAST) begin
          state_next = slrg_pkg::ST_DRAW;
        end else begin
          count_next = count + 1'b1;
        end
      end
      slrg_pkg::ST_DRAW: begin
        op         = slrg_pkg::RING_STEP;
        draw       = 1'b1;
        state_next = slrg_pkg::ST_IDLE;
      end
      default: begin
        state_next = slrg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slrg_pkg::ST_IDLE;
      count     <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == slrg_pkg::ST_DRAW) begin
        seeded <= 1'b1;
      end
      if (draw) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      deviate <= draw_word;
    end
  end

  slrg_fill u_fill (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fctl),
    .seed      (seed),
    .fill_word (fill_word)
  );

  slrg_ring u_ring (
    .clk       (clk),
    .op        (op),
    .fill_word (fill_word),
    .draw_word (draw_word)
  );

endmodule

// ===== rtl/slrg_checker.sv =====
`timescale 1ns / 1ps
`include "subtractive_lagged_random_generator_defines.svh"
module slrg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [31:0] seed,
  input logic               out_valid,
  input logic               out_ready,
  input logic [29:0]        deviate
);

  // a waiting result holds until its transfer
  `SLRG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(deviate))

  // every deviate is below the modulus
  `SLRG_ASSERT(a_dev_range, clk, rst, out_valid |-> deviate < 30'd1000000000)

  // a negative seed starts a rebuild: no request taken, no result pending
  `SLRG_ASSERT(a_reseed_busy, clk, rst, in_valid && in_ready && seed[31] |=> !in_ready && !out_valid)

  `SLRG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind subtractive_lagged_random_generator slrg_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  class deviate_scoreboard;
    slrg_pkg::word_t lag_words[56];
    int unsigned lead_idx;
    int unsigned lag_idx;
    bit seeded;
    slrg_pkg::word_t pending_deviates[$];
    int unsigned n_seeds;
    int unsigned n_reseeds;
    int unsigned n_checked;
    int unsigned n_errors;

    function slrg_pkg::word_t mod_diff(slrg_pkg::word_t a, slrg_pkg::word_t b);
      bit [slrg_pkg::WORD_W:0] wide;
      wide = {1'b0, a} + {1'b0, slrg_pkg::MODULUS} - {1'b0, b};
      if (a >= b) return a - b;
      return wide[slrg_pkg::WORD_W-1:0];
    endfunction

    function void rebuild_table(bit [63:0] mag);
      bit [63:0] dist_from_const;
      slrg_pkg::word_t cur;
      slrg_pkg::word_t nxt;
      int unsigned slot;
      dist_from_const = (mag >= 64'(slrg_pkg::SEED_CONST)) ? mag - 64'(slrg_pkg::SEED_CONST)
                                                           : 64'(slrg_pkg::SEED_CONST) - mag;
      cur = slrg_pkg::word_t'(dist_from_const % 64'(slrg_pkg::MODULUS));
      lag_words[slrg_pkg::TABLE_LEN] = cur;
      nxt = slrg_pkg::word_t'(1);
      // fill in permuted order
      for (int unsigned i = 1; i < slrg_pkg::TABLE_LEN; i++) begin
        slot = (slrg_pkg::PERM_STEP * i) % slrg_pkg::TABLE_LEN;
        lag_words[slot] = nxt;
        nxt = mod_diff(cur, nxt);
        cur = lag_words[slot];
      end
      for (int p = 0; p < slrg_pkg::WARM_PASSES; p++) begin
        for (int unsigned i = 1; i <= slrg_pkg::TABLE_LEN; i++) begin
          slot = 1 + (i + 30) % slrg_pkg::TABLE_LEN;
          lag_words[i] = mod_diff(lag_words[i], lag_words[slot]);
        end
      end
      lead_idx = 0;
      lag_idx = slrg_pkg::LAG_START;
      seeded = 1'b1;
      n_reseeds++;
    endfunction

    function slrg_pkg::word_t predict_deviate(logic [31:0] s);
      bit [63:0] mag;
      slrg_pkg::word_t v;
      // magnitude of the most negative seed is 2^31, kept exact
      mag = s[31] ? 64'h1_0000_0000 - {32'd0, s} : {32'd0, s};
      if (s[31] || !seeded) rebuild_table(mag);
      lead_idx = (lead_idx >= slrg_pkg::TABLE_LEN) ? 1 : lead_idx + 1;
      lag_idx = (lag_idx >= slrg_pkg::TABLE_LEN) ? 1 : lag_idx + 1;
      v = mod_diff(lag_words[lead_idx], lag_words[lag_idx]);
      lag_words[lead_idx] = v;
      return v;
    endfunction

    function void note_seed(logic [31:0] s);
      pending_deviates.push_back(predict_deviate(s));
      n_seeds++;
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      n_errors++;
    endtask

    task check_deviate(slrg_pkg::word_t got);
      slrg_pkg::word_t want;
      if (pending_deviates.size() == 0) begin
        report_mismatch($sformatf("deviate %0d with no request outstanding", got));
      end else begin
        want = pending_deviates.pop_front();
        n_checked++;
        if (got !== want)
          report_mismatch($sformatf("deviate %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] seed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [29:0]        deviate;

  deviate_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int stall_run = 0;
  logic hold_off = 1'b0;

  logic [31:0] directed_seeds[16] = '{
    32'd0,                // first request builds from a non-negative seed
    32'd5,                // ignored once seeded
    32'h7fff_ffff,
    32'h8000_0000,        // most negative seed
    32'd1,
    -32'sd1,
    32'd42,
    -32'sd2147483647,
    -32'sd161803398,      // first word zero
    32'd161803398,
    -32'sd1161803398,     // difference is exactly the modulus
    -32'sd1161803399,
    -32'sd161803397,
    -32'sd161803399,
    32'h5555_5555,
    32'haaaa_aaaa
  };

  subtractive_lagged_random_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .seed      (seed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .deviate   (deviate)
  );

  always #10 clk = ~clk;

  task automatic send_seed(input logic [31:0] s);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap++;
    end
    in_valid <= 1'b1;
    seed <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_seed(s);
  endtask

  function automatic logic [31:0] random_seed();
    logic [31:0] r;
    r = $urandom();
    // reseeds are slow, keep them rare
    r[31] = ($urandom_range(39) == 0);
    return r;
  endfunction

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_deviate(deviate);
    if (hold_off || (stall_run < 8 && $urandom_range(99) < stall_pct)) begin
      out_ready <= 1'b0;
      stall_run++;
    end else begin
      out_ready <= 1'b1;
      stall_run = 0;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    while (sb.n_seeds < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_seeds[i]) send_seed(directed_seeds[i]);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      repeat (400) send_seed(random_seed());
    end
    in_valid <= 1'b0;
    while (sb.pending_deviates.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d requests, %0d of them rebuilding the lag table",
             sb.n_seeds, sb.n_reseeds);
    $display("%0d deviates compared under four idle/stall mixes and a long hold-off",
             sb.n_checked);
    if (sb.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
